FILE: sv/bsc_pkg.sv
// Shared widths, constants and register codes of the barometer compensation block.
package bsc_pkg;

  localparam int RAW_W        = 24;
  localparam int ADC_BITS_DEF = 24;
  localparam int CAL_W        = 16;
  localparam int TEMP_W       = 19;
  localparam int PRESS_W      = 32;
  localparam int IDX_W        = 3;

  // Pipeline depth, one register stage each.
  localparam int PIPE_DEPTH = 9;

  // dT spans a full raw conversion minus the reference word shifted by eight.
  localparam int DT_W   = CAL_W + 9;
  localparam int PT_W   = DT_W + CAL_W + 1;
  localparam int DTSQ_W = 2 * DT_W;
  localparam int T2_W   = 18;
  localparam int DIFF_W = TEMP_W + 1;
  localparam int SQ_W   = 36;
  localparam int OFF_W  = 40;
  localparam int COR_W  = 40;
  localparam int LO_W   = 20;

  localparam int TEMP_SHIFT  = 23;
  localparam int OFF_SHIFT   = 7;
  localparam int SENS_SHIFT  = 8;
  localparam int T2_SHIFT    = 31;
  localparam int PROD_SHIFT  = 21;
  localparam int PRESS_SHIFT = 15;

  localparam logic signed [TEMP_W-1:0] TEMP_NOMINAL = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD    = -19'sd1500;

  localparam longint PRESS_MAX = 64'sd2147483647;
  localparam longint PRESS_MIN = -64'sd2147483648;

  typedef enum logic [IDX_W-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } reg_index_t;

endpackage

FILE: sv/bsc_channel_if.sv
// Handshake channels for raw conversion requests and compensated results.
interface bsc_sample_if import bsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] pressure_raw;
  logic [RAW_W-1:0] temperature_raw;

  modport source (output valid, pressure_raw, temperature_raw, input ready);
  modport sink   (input valid, pressure_raw, temperature_raw, output ready);
endinterface

interface bsc_result_if import bsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PRESS_W-1:0] pressure;
  logic signed [TEMP_W-1:0]  temperature;

  modport source (output valid, pressure, temperature, input ready);
  modport sink   (input valid, pressure, temperature, output ready);
endinterface

FILE: sv/bsc_split_mul.sv
// Registered unsigned-by-signed multiplier split into two narrower partial products.
module bsc_split_mul import bsc_pkg::*; #(
  parameter int A_W = ADC_BITS_DEF,
  parameter int B_W = OFF_W,
  parameter int P_W = LO_W
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [A_W-1:0]             a,
  input  logic signed [B_W-1:0]      b,
  output logic [A_W+P_W-1:0]         lo,
  output logic signed [A_W+B_W-P_W:0] hi
);

  logic [A_W+P_W-1:0]          lo_next;
  logic signed [A_W+B_W-P_W:0] hi_next;

  // The low part of b is unsigned, the high part carries the sign.
  always_comb begin
    lo_next = a * b[P_W-1:0];
    hi_next = $signed({1'b0, a}) * $signed(b[B_W-1:P_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

endmodule

FILE: sv/barometer_second_order_compensation.sv
// Top level of the barometer compensation pipeline.
// Usage: write the six factory calibration words through wr_en, wr_index and wr_data
// (index 0 to 5, higher indexes are ignored) while no request is in flight. Each request
// on the sample channel carries one raw pressure and one raw temperature conversion and
// gives exactly one result on the result channel: compensated pressure in 0.01 mbar,
// saturated to 32-bit signed, and temperature in 0.01 C, second-order corrected below
// 20.00 C; the pressure correction gains an extra term below -15.00 C.
// Throughput is one request per cycle while the receiver takes results; the nine
// register stages are set by the multiplier chain, whose widest steps are the 25x25
// square of dT and the two 24x20 partial products of the pressure multiply.
// Every stage holds a valid bit and loads when it is empty or when the stage after it
// moves, so bubbles close up while the receiver stalls and the pipeline keeps accepting
// until all nine stages are full; a stalled result holds steady on the result channel.
// Reset clears all valid bits and the calibration words to zero.
module barometer_second_order_compensation import bsc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [CAL_W-1:0]  wr_data,
  bsc_sample_if.sink        sample,
  bsc_result_if.source      result
);

  localparam int NS     = PIPE_DEPTH;
  localparam int HI_W   = ADC_BITS + OFF_W - LO_W + 1;
  localparam int PLO_W  = ADC_BITS + LO_W;
  localparam int PROD_W = ADC_BITS + OFF_W + 2;
  localparam int X_W    = ((PROD_W - PROD_SHIFT > OFF_W) ? PROD_W - PROD_SHIFT : OFF_W) + 1;
  localparam logic signed [X_W-1:0] P_MAX = X_W'(PRESS_MAX);
  localparam logic signed [X_W-1:0] P_MIN = X_W'(PRESS_MIN);

  // Calibration words.
  logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_SENS:     c1 <= wr_data;
        REG_OFF:      c2 <= wr_data;
        REG_TCS:      c3 <= wr_data;
        REG_TCO:      c4 <= wr_data;
        REG_TREF:     c5 <= wr_data;
        REG_TEMPSENS: c6 <= wr_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables.
  logic [NS:1]   v;
  logic [NS:0]   v_chain;
  logic [NS+1:1] en;

  assign v_chain = {v, sample.valid};

  always_comb begin
    en[NS+1] = result.ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign sample.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v[k] <= v_chain[k-1];
        end
      end
    end
  end

  // Stage 1: mask the conversions and form dT.
  logic [ADC_BITS-1:0]    d1_1;
  logic signed [DT_W-1:0] dt_1, dt_next;

  assign dt_next = $signed(DT_W'(sample.temperature_raw[ADC_BITS-1:0]))
                 - $signed({1'b0, c5, 8'b0});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_1 <= sample.pressure_raw[ADC_BITS-1:0];
      dt_1 <= dt_next;
    end
  end

  // Stage 2: the four products of dT.
  logic [ADC_BITS-1:0]      d1_2;
  logic signed [PT_W-1:0]   pt_2, poff_2, psens_2;
  logic signed [DTSQ_W-1:0] dtsq_2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_2    <= d1_1;
      pt_2    <= dt_1 * $signed({1'b0, c6});
      poff_2  <= dt_1 * $signed({1'b0, c4});
      psens_2 <= dt_1 * $signed({1'b0, c3});
      dtsq_2  <= dt_1 * dt_1;
    end
  end

  // Stage 3: first-order temperature, offset and sensitivity.
  logic [ADC_BITS-1:0]      d1_3;
  logic signed [TEMP_W-1:0] temp_3;
  logic signed [OFF_W-1:0]  off_3, sens_3;
  logic [T2_W-1:0]          t2_3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d1_3   <= d1_2;
      temp_3 <= TEMP_NOMINAL + TEMP_W'(pt_2 >>> TEMP_SHIFT);
      off_3  <= $signed(OFF_W'({c2, 16'b0})) + OFF_W'(poff_2 >>> OFF_SHIFT);
      sens_3 <= $signed(OFF_W'({c1, 15'b0})) + OFF_W'(psens_2 >>> SENS_SHIFT);
      t2_3   <= T2_W'(dtsq_2 >>> T2_SHIFT);
    end
  end

  // Stage 4: range flags, squared distances and the corrected temperature.
  logic signed [DIFF_W-1:0] da, db;
  logic                     lo_4, vlo_4;
  logic [SQ_W-1:0]          sqa_4, sqb_4;
  logic [ADC_BITS-1:0]      d1_4;
  logic signed [TEMP_W-1:0] temp_4;
  logic signed [OFF_W-1:0]  off_4, sens_4;
  logic                     lo_next;

  always_comb begin
    da      = DIFF_W'(temp_3) - DIFF_W'(TEMP_NOMINAL);
    db      = DIFF_W'(temp_3) - DIFF_W'(TEMP_COLD);
    lo_next = temp_3 < TEMP_NOMINAL;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d1_4   <= d1_3;
      off_4  <= off_3;
      sens_4 <= sens_3;
      lo_4   <= lo_next;
      vlo_4  <= temp_3 < TEMP_COLD;
      sqa_4  <= SQ_W'(da) * SQ_W'(da);
      sqb_4  <= SQ_W'(db) * SQ_W'(db);
      temp_4 <= lo_next ? temp_3 - $signed({1'b0, t2_3}) : temp_3;
    end
  end

  // Stage 5: offset and sensitivity corrections.
  logic [COR_W-1:0]         five_a, seven_b, eleven_b, off2_next, sens2_next;
  logic [COR_W-1:0]         off2_5, sens2_5;
  logic [ADC_BITS-1:0]      d1_5;
  logic signed [TEMP_W-1:0] temp_5;
  logic signed [OFF_W-1:0]  off_5, sens_5;

  always_comb begin
    five_a   = (COR_W'(sqa_4) << 2) + COR_W'(sqa_4);
    seven_b  = (COR_W'(sqb_4) << 3) - COR_W'(sqb_4);
    eleven_b = (COR_W'(sqb_4) << 3) + (COR_W'(sqb_4) << 1) + COR_W'(sqb_4);
    off2_next  = '0;
    sens2_next = '0;
    if (lo_4) begin
      off2_next  = five_a >> 1;
      sens2_next = five_a >> 2;
      if (vlo_4) begin
        off2_next  = off2_next + seven_b;
        sens2_next = sens2_next + (eleven_b >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      d1_5    <= d1_4;
      temp_5  <= temp_4;
      off_5   <= off_4;
      sens_5  <= sens_4;
      off2_5  <= off2_next;
      sens2_5 <= sens2_next;
    end
  end

  // Stage 6: corrected offset and sensitivity.
  logic [ADC_BITS-1:0]      d1_6;
  logic signed [TEMP_W-1:0] temp_6;
  logic signed [OFF_W-1:0]  off_6, sens_6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      d1_6   <= d1_5;
      temp_6 <= temp_5;
      off_6  <= off_5 - $signed(off2_5);
      sens_6 <= sens_5 - $signed(sens2_5);
    end
  end

  // Stage 7: partial products of the raw pressure and the sensitivity.
  logic [PLO_W-1:0]         plo_7;
  logic signed [HI_W-1:0]   phi_7;
  logic signed [TEMP_W-1:0] temp_7;
  logic signed [OFF_W-1:0]  off_7;

  bsc_split_mul #(
    .A_W (ADC_BITS),
    .B_W (OFF_W),
    .P_W (LO_W)
  ) u_mul (
    .clk (clk),
    .en  (en[7]),
    .a   (d1_6),
    .b   (sens_6),
    .lo  (plo_7),
    .hi  (phi_7)
  );

  always_ff @(posedge clk) begin
    if (en[7]) begin
      temp_7 <= temp_6;
      off_7  <= off_6;
    end
  end

  // Stage 8: recombine the product, scale and remove the offset.
  logic signed [PROD_W-1:0] prod;
  logic signed [X_W-1:0]    x_8;
  logic signed [TEMP_W-1:0] temp_8;

  assign prod = (PROD_W'(phi_7) <<< LO_W) + $signed(PROD_W'(plo_7));

  always_ff @(posedge clk) begin
    if (en[8]) begin
      temp_8 <= temp_7;
      x_8    <= X_W'(prod >>> PROD_SHIFT) - X_W'(off_7);
    end
  end

  // Stage 9: final scaling and saturation into the result register.
  logic signed [X_W-1:0]     pfull;
  logic signed [PRESS_W-1:0] press_next, press_9;
  logic signed [TEMP_W-1:0]  temp_9;

  always_comb begin
    pfull = x_8 >>> PRESS_SHIFT;
    priority if (pfull > P_MAX) begin
      press_next = PRESS_W'(P_MAX);
    end else if (pfull < P_MIN) begin
      press_next = PRESS_W'(P_MIN);
    end else begin
      press_next = PRESS_W'(pfull);
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      temp_9  <= temp_8;
      press_9 <= press_next;
    end
  end

  assign result.valid       = v[NS];
  assign result.pressure    = press_9;
  assign result.temperature = temp_9;

endmodule

FILE: sv/bsc_checker.sv
// Port-level checks of the barometer compensation block and their bind.
module bsc_checker import bsc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [PRESS_W-1:0] out_pressure,
  input logic signed [TEMP_W-1:0]  out_temperature
);

  // Reset empties every stage, so no result can show right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The block only refuses a request when it is full and the receiver stalls.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("request refused without a stalled result");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result withdrawn");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_pressure) && $stable(out_temperature)))
    else $error("stalled result changed");

endmodule

bind barometer_second_order_compensation bsc_checker u_bsc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (sample.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_pressure    (result.pressure),
  .out_temperature (result.temperature)
);

FILE: test/tb_barometer_second_order_compensation.sv
// Testbench for the barometer second-order compensation pipeline.
module tb_barometer_second_order_compensation;
  import bsc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD    = 80;
  localparam int PHASE_ITEMS  = 190;
  localparam int NUM_PHASES   = 6;

  typedef struct {
    logic signed [PRESS_W-1:0] pressure;
    logic signed [TEMP_W-1:0]  temperature;
  } reading_t;

  // Keeps the calibration words and the compensated readings still owed by the block.
  class reading_scoreboard;
    logic [CAL_W-1:0] cal [0:5];
    reading_t         owed_q [$];
    int               errors;

    function new();
      for (int i = 0; i < 6; i++) cal[i] = '0;
      errors = 0;
    endfunction

    function void write_cal(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] val);
      if (idx <= REG_TEMPSENS) cal[idx] = val;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function reading_t compensate(logic [RAW_W-1:0] p_raw, logic [RAW_W-1:0] t_raw);
      longint   adc_mask, d1, d2, c1, c2, c3, c4, c5, c6;
      longint   dt, tc, off, sens, t2, off2, sens2, dd, p;
      reading_t r;
      adc_mask = (64'sd1 <<< ADC_BITS_DEF) - 64'sd1;
      d1 = longint'(p_raw) & adc_mask;
      d2 = longint'(t_raw) & adc_mask;
      c1 = longint'(cal[REG_SENS]);
      c2 = longint'(cal[REG_OFF]);
      c3 = longint'(cal[REG_TCS]);
      c4 = longint'(cal[REG_TCO]);
      c5 = longint'(cal[REG_TREF]);
      c6 = longint'(cal[REG_TEMPSENS]);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      dt   = d2 - c5 * 256;
      tc   = longint'(TEMP_NOMINAL) + ((dt * c6) >>> TEMP_SHIFT);
      off  = c2 * 65536 + ((c4 * dt) >>> OFF_SHIFT);
      sens = c1 * 32768 + ((c3 * dt) >>> SENS_SHIFT);
      if (tc < longint'(TEMP_NOMINAL)) begin
        dd    = tc - longint'(TEMP_NOMINAL);
        t2    = (dt * dt) >>> T2_SHIFT;
        off2  = (5 * dd * dd) >>> 1;
        sens2 = (5 * dd * dd) >>> 2;
        if (tc < longint'(TEMP_COLD)) begin
          dd    = tc - longint'(TEMP_COLD);
          off2  = off2 + 7 * dd * dd;
          sens2 = sens2 + ((11 * dd * dd) >>> 1);
        end
      end
      tc   = tc - t2;
      off  = off - off2;
      sens = sens - sens2;
      p = (((d1 * sens) >>> PROD_SHIFT) - off) >>> PRESS_SHIFT;
      if (p > PRESS_MAX) p = PRESS_MAX;
      if (p < PRESS_MIN) p = PRESS_MIN;
      r.pressure    = p[PRESS_W-1:0];
      r.temperature = tc[TEMP_W-1:0];
      return r;
    endfunction

    function void note_request(logic [RAW_W-1:0] p_raw, logic [RAW_W-1:0] t_raw);
      owed_q.push_back(compensate(p_raw, t_raw));
    endfunction

    task report(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [PRESS_W-1:0] p, logic signed [TEMP_W-1:0] t);
      reading_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result pressure=%0d temperature=%0d", p, t));
      end else begin
        want = owed_q.pop_front();
        if (p !== want.pressure)
          report($sformatf("pressure got %0d want %0d", p, want.pressure));
        if (t !== want.temperature)
          report($sformatf("temperature got %0d want %0d", t, want.temperature));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CAL_W-1:0] wr_data;

  bsc_sample_if sample_ch ();
  bsc_result_if result_ch ();

  barometer_second_order_compensation dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sample   (sample_ch),
    .result   (result_ch)
  );

  reading_scoreboard sb;
  logic [CAL_W-1:0]  next_cal [0:5];
  bit                bursts_on;
  bit                hold_off_req;
  int                cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Writes all six calibration words, and junk to the unused indexes when asked.
  task automatic load_cal(input bit poke_unused);
    for (int i = 0; i < 6; i++) begin
      wr_en    <= 1'b1;
      wr_index <= IDX_W'(i);
      wr_data  <= next_cal[i];
      @(posedge clk);
      sb.write_cal(IDX_W'(i), next_cal[i]);
    end
    if (poke_unused) begin
      for (int i = REG_TEMPSENS + 1; i < (1 << IDX_W); i++) begin
        wr_en    <= 1'b1;
        wr_index <= IDX_W'(i);
        wr_data  <= CAL_W'($urandom);
        @(posedge clk);
      end
    end
    wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic send_request(input logic [RAW_W-1:0] p_raw, input logic [RAW_W-1:0] t_raw);
    int gap;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.pressure_raw    <= p_raw;
    sample_ch.temperature_raw <= t_raw;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_request(p_raw, t_raw);
  endtask

  // Raw temperature that lands near a target temperature under the current calibration.
  function automatic logic [RAW_W-1:0] raw_for_temp(input int target);
    longint c5, c6, d2;
    c5 = longint'(sb.cal[REG_TREF]);
    c6 = longint'(sb.cal[REG_TEMPSENS]);
    if (c6 == 0) return RAW_W'($urandom);
    d2 = c5 * 256 + ((longint'(target) - longint'(TEMP_NOMINAL)) <<< TEMP_SHIFT) / c6;
    if (d2 < 0) d2 = 0;
    if (d2 > (64'sd1 <<< RAW_W) - 1) d2 = (64'sd1 <<< RAW_W) - 1;
    return d2[RAW_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] pick_temp_raw();
    int     sel;
    longint base, off;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      base = longint'(sb.cal[REG_TREF]) * 256;
      off  = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      base = base + off;
      if (base < 0) base = 0;
      if (base > (64'sd1 <<< RAW_W) - 1) base = (64'sd1 <<< RAW_W) - 1;
      return base[RAW_W-1:0];
    end else if (sel < 65) begin
      return raw_for_temp($urandom_range(0, 8000) - 4000);
    end else if (sel < 85) begin
      return RAW_W'($urandom);
    end else if (sel < 92) begin
      return RAW_W'($urandom_range(0, 255));
    end else begin
      return {RAW_W{1'b1}} - RAW_W'($urandom_range(0, 255));
    end
  endfunction

  function automatic logic [RAW_W-1:0] pick_press_raw();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return RAW_W'($urandom);
    if (sel == 7) return RAW_W'(9085466 + $urandom_range(0, 200000) - 100000);
    if (sel == 8) return RAW_W'($urandom_range(0, 15));
    return {RAW_W{1'b1}} - RAW_W'($urandom_range(0, 15));
  endfunction

  task automatic set_typical_cal();
    next_cal[REG_SENS]     = 16'd40127;
    next_cal[REG_OFF]      = 16'd36924;
    next_cal[REG_TCS]      = 16'd23317;
    next_cal[REG_TCO]      = 16'd23282;
    next_cal[REG_TREF]     = 16'd33464;
    next_cal[REG_TEMPSENS] = 16'd28312;
  endtask

  // Receiving side: checks results and throttles ready.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.pressure, result_ch.temperature);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        result_ch.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    bursts_on = 1'b1;
    hold_off_req = 1'b0;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.pressure_raw <= '0;
    sample_ch.temperature_raw <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: calibration still at reset, raw extremes.
    send_request('0, '0);
    send_request({RAW_W{1'b1}}, {RAW_W{1'b1}});
    send_request({RAW_W{1'b1}}, '0);
    send_request('0, {RAW_W{1'b1}});
    wait_drained();

    // Directed: typical calibration around both correction thresholds.
    set_typical_cal();
    load_cal(1'b1);
    send_request(24'd9085466, raw_for_temp(2000));
    send_request(24'd9085466, raw_for_temp(2001));
    send_request(24'd9085466, raw_for_temp(1999));
    send_request(24'd9085466, raw_for_temp(-1499));
    send_request(24'd9085466, raw_for_temp(-1500));
    send_request(24'd9085466, raw_for_temp(-1501));
    send_request(24'd9085466, 24'(longint'(sb.cal[REG_TREF]) * 256));
    send_request(24'd9085466, 24'(longint'(sb.cal[REG_TREF]) * 256 - 1));
    send_request({RAW_W{1'b1}}, '0);
    send_request('0, {RAW_W{1'b1}});
    wait_drained();

    // Directed: every calibration word at its maximum, deepest cold and hottest.
    for (int i = 0; i < 6; i++) next_cal[i] = {CAL_W{1'b1}};
    load_cal(1'b0);
    send_request({RAW_W{1'b1}}, '0);
    send_request('0, '0);
    send_request({RAW_W{1'b1}}, {RAW_W{1'b1}});
    send_request('0, {RAW_W{1'b1}});
    send_request({RAW_W{1'b1}}, raw_for_temp(-1501));
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0, 5: set_typical_cal();
        1: for (int i = 0; i < 6; i++) next_cal[i] = {CAL_W{1'b1}};
        3: for (int i = 0; i < 6; i++) next_cal[i] = CAL_W'($urandom_range(20000, 50000));
        default: for (int i = 0; i < 6; i++) next_cal[i] = CAL_W'($urandom);
      endcase
      if (ph == 2) next_cal[REG_TEMPSENS] = '0;
      load_cal(ph % 2 == 0);
      bursts_on = (ph != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the receiver off long enough for the pipeline to fill and back up.
        if (ph == 0 && n == 20) hold_off_req = 1'b1;
        // Let everything in flight come out before going on.
        if (ph == 1 && n == 60) begin
          sample_ch.valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        send_request(pick_press_raw(), pick_temp_raw());
      end
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
